[src/lsra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared constants and control types of the linear scan register allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

  // default sizes of the register classes and fields
  localparam int INT_REGS_DEF = 7;
  localparam int FP_REGS_DEF  = 27;
  localparam int POS_BITS_DEF = 16;
  localparam int ID_BITS_DEF  = 12;

  // physical register numbering
  localparam int REG_W      = 6;
  localparam int INT_BASE   = 4;
  localparam int FLOAT_BASE = 21;

  // active table operations
  typedef logic [1:0] tbl_op_t;
  localparam tbl_op_t TBL_NOP  = 2'd0;
  localparam tbl_op_t TBL_ROT  = 2'd1;
  localparam tbl_op_t TBL_DROP = 2'd2;
  localparam tbl_op_t TBL_PUSH = 2'd3;

  typedef struct packed {
    logic    clear;
    tbl_op_t op;
  } tbl_ctrl_t;

  typedef struct packed {
    logic refill;
    logic alloc;
    logic free;
    logic cls;
  } pool_ctrl_t;

endpackage

[src/linear_scan_register_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_scan_register_allocator
// Linear scan register allocation of live intervals, one request at a time.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; s_tready is high only while the sequencer
// is idle. Each request first expires the ended entries at the head of the
// sorted table, then takes a free register of its class if there is one.
// With the class full, the victim search walks the sorted table one entry per
// cycle through a single compare unit at its head. An allocation or a victim
// replacement then rebuilds the table by rotating it through the head; a
// spilled new interval skips the rebuild. A result that waits on m_tready holds
// the sequencer. A victim replacement yields two results: the spilled victim (tlast low), then the new interval.
module linear_scan_register_allocator #(
  parameter int INT_REGS = lsra_pkg::INT_REGS_DEF,
  parameter int FP_REGS  = lsra_pkg::FP_REGS_DEF,
  parameter int POS_BITS = lsra_pkg::POS_BITS_DEF,
  parameter int ID_BITS  = lsra_pkg::ID_BITS_DEF,
  localparam int IN_W    = ID_BITS + 2 * POS_BITS,
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W   = ID_BITS + lsra_pkg::REG_W,
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,   // interval_id, interval_start, interval_end
  input  logic [1:0]        s_tuser,   // fp_class, first_of_pass
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata,   // result_id, phys_reg
  output logic [1:0]        m_tuser,   // spilled, any_spill
  output logic              m_tlast
);

  localparam int DEPTH = INT_REGS + FP_REGS;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RW    = lsra_pkg::REG_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXPIRE  = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_SEARCH  = 3'd3;
  localparam logic [2:0] S_JUDGE   = 3'd4;
  localparam logic [2:0] S_REBUILD = 3'd5;
  localparam logic [2:0] S_EMIT_A  = 3'd6;
  localparam logic [2:0] S_EMIT_B  = 3'd7;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_REPLACE = 2'd1;
  localparam logic [1:0] KIND_SPILL   = 2'd2;

  logic [2:0]          state;
  logic [1:0]          kind;
  logic [ID_BITS-1:0]  item_id;
  logic [POS_BITS-1:0] item_start;
  logic [POS_BITS-1:0] item_end;
  logic                item_flt;
  logic [RW-1:0]       new_reg;
  logic                spill_flag;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       idx;
  logic                inserted;
  logic                vic_found;
  logic [CW-1:0]       vic_pos;
  logic [POS_BITS-1:0] vic_end;
  logic [ID_BITS-1:0]  vic_id;
  logic [RW-1:0]       vic_reg;

  logic [ID_BITS-1:0]  out_id;
  logic [RW-1:0]       out_reg;
  logic                out_spilled;
  logic                out_any;
  logic                out_last;

  lsra_pkg::tbl_ctrl_t  tbl_ctrl;
  lsra_pkg::pool_ctrl_t pool_ctrl;

  logic [ID_BITS-1:0]  head_id;
  logic [POS_BITS-1:0] head_end;
  logic [RW-1:0]       head_reg;
  logic                head_flt;
  logic [CW-1:0]       count;
  logic                has_free;
  logic [RW-1:0]       alloc_reg;

  logic [POS_BITS-1:0] cmp_a;
  logic [POS_BITS-1:0] cmp_b;
  logic [POS_BITS:0]   cmp_diff;
  logic                cmp_lt;
  logic                cmp_gt;

  logic accept;
  logic out_free;
  logic drop_here;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign drop_here = (kind == KIND_REPLACE) && (cnt != '0) && (idx == vic_pos);

  // shared compare unit
  assign cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
  assign cmp_lt   = cmp_diff[POS_BITS];
  assign cmp_gt   = !cmp_lt && (cmp_diff != '0);

  always_comb begin
    tbl_ctrl  = '{clear: 1'b0, op: lsra_pkg::TBL_NOP};
    pool_ctrl = '0;
    cmp_a     = head_end;
    cmp_b     = item_end;
    unique case (state)
      S_IDLE: begin
        if (accept && s_tuser[1]) begin
          tbl_ctrl.clear   = 1'b1;
          pool_ctrl.refill = 1'b1;
        end
      end
      S_EXPIRE: begin
        cmp_b = item_start;
        pool_ctrl.cls = head_flt;
        if (count != '0 && cmp_lt) begin
          pool_ctrl.free = 1'b1;
          tbl_ctrl.op    = lsra_pkg::TBL_DROP;
        end
      end
      S_DECIDE: begin
        pool_ctrl.cls   = item_flt;
        pool_ctrl.alloc = has_free;
      end
      S_SEARCH: begin
        if (cnt != '0) tbl_ctrl.op = lsra_pkg::TBL_ROT;
      end
      S_JUDGE: begin
        cmp_a = vic_end;
      end
      S_REBUILD: begin
        if (drop_here) begin
          tbl_ctrl.op = lsra_pkg::TBL_DROP;
        end else if (!inserted && (cnt == '0 || cmp_gt)) begin
          tbl_ctrl.op = lsra_pkg::TBL_PUSH;
        end else if (cnt != '0) begin
          tbl_ctrl.op = lsra_pkg::TBL_ROT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      spill_flag <= 1'b0;
      kind       <= KIND_ALLOC;
      cnt        <= '0;
      idx        <= '0;
      inserted   <= 1'b0;
      vic_found  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_id    <= s_tdata[ID_BITS-1:0];
            item_start <= s_tdata[ID_BITS +: POS_BITS];
            item_end   <= s_tdata[ID_BITS+POS_BITS +: POS_BITS];
            item_flt   <= s_tuser[0];
            if (s_tuser[1]) spill_flag <= 1'b0;
            state <= S_EXPIRE;
          end
        end
        S_EXPIRE: begin
          if (!(count != '0 && cmp_lt)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          cnt      <= count;
          idx      <= '0;
          inserted <= 1'b0;
          if (has_free) begin
            kind    <= KIND_ALLOC;
            new_reg <= alloc_reg;
            state   <= S_REBUILD;
          end else begin
            vic_found <= 1'b0;
            state     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (cnt == '0) begin
            state <= S_JUDGE;
          end else begin
            // the last matching entry in end order becomes the victim
            if (head_flt == item_flt) begin
              vic_found <= 1'b1;
              vic_pos   <= idx;
              vic_end   <= head_end;
              vic_id    <= head_id;
              vic_reg   <= head_reg;
            end
            cnt <= cnt - CW'(1);
            idx <= idx + CW'(1);
          end
        end
        S_JUDGE: begin
          spill_flag <= 1'b1;
          cnt        <= count;
          idx        <= '0;
          inserted   <= 1'b0;
          if (vic_found && cmp_gt) begin
            kind    <= KIND_REPLACE;
            new_reg <= vic_reg;
            state   <= S_REBUILD;
          end else begin
            kind  <= KIND_SPILL;
            state <= S_EMIT_A;
          end
        end
        S_REBUILD: begin
          if (drop_here) begin
            cnt <= cnt - CW'(1);
            idx <= idx + CW'(1);
          end else if (!inserted && cnt != '0 && cmp_gt) begin
            inserted <= 1'b1;
          end else if (cnt != '0) begin
            cnt <= cnt - CW'(1);
            idx <= idx + CW'(1);
          end else begin
            state <= S_EMIT_A;
          end
        end
        S_EMIT_A: begin
          if (out_free) state <= (kind == KIND_REPLACE) ? S_EMIT_B : S_IDLE;
        end
        S_EMIT_B: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_EMIT_A || state == S_EMIT_B) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_any <= spill_flag;
      if (state == S_EMIT_A && kind == KIND_REPLACE) begin
        out_id      <= vic_id;
        out_reg     <= '0;
        out_spilled <= 1'b1;
        out_last    <= 1'b0;
      end else if (state == S_EMIT_A && kind == KIND_SPILL) begin
        out_id      <= item_id;
        out_reg     <= '0;
        out_spilled <= 1'b1;
        out_last    <= 1'b1;
      end else begin
        out_id      <= item_id;
        out_reg     <= new_reg;
        out_spilled <= 1'b0;
        out_last    <= 1'b1;
      end
    end
  end

  assign m_tdata = OUT_TW'({out_reg, out_id});
  assign m_tuser = {out_any, out_spilled};
  assign m_tlast = out_last;

  lsra_table #(
    .DEPTH    (DEPTH),
    .POS_BITS (POS_BITS),
    .ID_BITS  (ID_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (tbl_ctrl),
    .new_id   (item_id),
    .new_end  (item_end),
    .new_reg  (new_reg),
    .new_flt  (item_flt),
    .head_id  (head_id),
    .head_end (head_end),
    .head_reg (head_reg),
    .head_flt (head_flt),
    .count    (count)
  );

  lsra_pool #(
    .INT_REGS (INT_REGS),
    .FP_REGS  (FP_REGS)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (pool_ctrl),
    .rel_reg   (head_reg),
    .has_free  (has_free),
    .alloc_reg (alloc_reg)
  );

endmodule

[src/lsra_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_table
// Active interval table kept sorted by end. Only the head entry is visible;
// the sequencer walks the table by rotating it through the head.
// ----------------------------------------------------------------------------
module lsra_table #(
  parameter int DEPTH    = lsra_pkg::INT_REGS_DEF + lsra_pkg::FP_REGS_DEF,
  parameter int POS_BITS = lsra_pkg::POS_BITS_DEF,
  parameter int ID_BITS  = lsra_pkg::ID_BITS_DEF,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lsra_pkg::tbl_ctrl_t          ctrl,
  input  logic [ID_BITS-1:0]           new_id,
  input  logic [POS_BITS-1:0]          new_end,
  input  logic [lsra_pkg::REG_W-1:0]   new_reg,
  input  logic                         new_flt,
  output logic [ID_BITS-1:0]           head_id,
  output logic [POS_BITS-1:0]          head_end,
  output logic [lsra_pkg::REG_W-1:0]   head_reg,
  output logic                         head_flt,
  output logic [CW-1:0]                count
);

  localparam int EW = ID_BITS + POS_BITS + lsra_pkg::REG_W + 1;

  logic [EW-1:0] ent [DEPTH];
  logic [EW-1:0] new_ent;
  logic [CW-1:0] tail;

  assign new_ent = {new_flt, new_reg, new_end, new_id};
  assign tail    = count - CW'(1);

  assign head_id  = ent[0][ID_BITS-1:0];
  assign head_end = ent[0][ID_BITS +: POS_BITS];
  assign head_reg = ent[0][ID_BITS+POS_BITS +: lsra_pkg::REG_W];
  assign head_flt = ent[0][EW-1];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      lsra_pkg::TBL_ROT: begin
        // head moves to the tail slot, the rest moves up one place
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == tail) begin
            ent[i] <= ent[0];
          end else if (i < DEPTH - 1) begin
            ent[i] <= ent[(i + 1) % DEPTH];
          end
        end
      end
      lsra_pkg::TBL_DROP: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          ent[i] <= ent[i + 1];
        end
      end
      lsra_pkg::TBL_PUSH: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == count) begin
            ent[i] <= new_ent;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
    end else begin
      unique case (ctrl.op)
        lsra_pkg::TBL_DROP: begin
          if (count != '0) count <= count - CW'(1);
        end
        lsra_pkg::TBL_PUSH: begin
          if (count != CW'(DEPTH)) count <= count + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/lsra_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_pool
// Free register bitmaps of the integer and float classes, with lowest-free
// selection, allocation, release and refill.
// ----------------------------------------------------------------------------
module lsra_pool #(
  parameter int INT_REGS = lsra_pkg::INT_REGS_DEF,
  parameter int FP_REGS  = lsra_pkg::FP_REGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lsra_pkg::pool_ctrl_t        ctrl,
  input  logic [lsra_pkg::REG_W-1:0]  rel_reg,
  output logic                        has_free,
  output logic [lsra_pkg::REG_W-1:0]  alloc_reg
);

  localparam int RW = lsra_pkg::REG_W;

  logic [INT_REGS-1:0] imap;
  logic [FP_REGS-1:0]  fmap;
  logic [INT_REGS-1:0] ilow;
  logic [FP_REGS-1:0]  flow;
  logic [RW-1:0]       ioff;
  logic [RW-1:0]       foff;
  logic [RW-1:0]       rel_off;

  // isolate the lowest set bit
  assign ilow = imap & (~imap + INT_REGS'(1));
  assign flow = fmap & (~fmap + FP_REGS'(1));

  always_comb begin
    ioff = '0;
    foff = '0;
    for (int i = 0; i < INT_REGS; i++) begin
      if (ilow[i]) ioff = ioff | RW'(i);
    end
    for (int i = 0; i < FP_REGS; i++) begin
      if (flow[i]) foff = foff | RW'(i);
    end
  end

  assign has_free  = ctrl.cls ? (|fmap) : (|imap);
  assign alloc_reg = ctrl.cls ? (RW'(lsra_pkg::FLOAT_BASE) + foff)
                              : (RW'(lsra_pkg::INT_BASE) + ioff);
  assign rel_off   = ctrl.cls ? (rel_reg - RW'(lsra_pkg::FLOAT_BASE))
                              : (rel_reg - RW'(lsra_pkg::INT_BASE));

  always_ff @(posedge clk) begin
    if (rst || ctrl.refill) begin
      imap <= {INT_REGS{1'b1}};
      fmap <= {FP_REGS{1'b1}};
    end else if (ctrl.alloc) begin
      if (ctrl.cls) fmap <= fmap & ~flow;
      else          imap <= imap & ~ilow;
    end else if (ctrl.free) begin
      if (ctrl.cls) fmap <= fmap | (FP_REGS'(1) << rel_off);
      else          imap <= imap | (INT_REGS'(1) << rel_off);
    end
  end

endmodule

[src/lsra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_checker
// Port-level checks of the register allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lsra_checker #(
  parameter int INT_REGS = lsra_pkg::INT_REGS_DEF,
  parameter int FP_REGS  = lsra_pkg::FP_REGS_DEF,
  parameter int ID_BITS  = lsra_pkg::ID_BITS_DEF,
  localparam int OUT_W   = ID_BITS + lsra_pkg::REG_W,
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_TW-1:0] m_tdata,
  input logic [1:0]        m_tuser,
  input logic              m_tlast
);

  localparam int RW = lsra_pkg::REG_W;

  logic [RW-1:0] phys;
  logic          int_range;
  logic          flt_range;

  assign phys      = m_tdata[ID_BITS +: RW];
  assign int_range = (phys >= RW'(lsra_pkg::INT_BASE)) &&
                     (phys < RW'(lsra_pkg::INT_BASE + INT_REGS));
  assign flt_range = (phys >= RW'(lsra_pkg::FLOAT_BASE)) &&
                     (phys < RW'(lsra_pkg::FLOAT_BASE + FP_REGS));

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_spill_no_reg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> phys == '0)
    else $error("spilled result carries a register");

  a_reg_in_class: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> int_range || flt_range)
    else $error("assigned register outside both classes");

  // a victim result only comes with a spill in the pass
  a_victim_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[0] && m_tuser[1])
    else $error("victim result without spill marks");

endmodule

bind linear_scan_register_allocator lsra_checker #(
  .INT_REGS (INT_REGS),
  .FP_REGS  (FP_REGS),
  .ID_BITS  (ID_BITS)
) u_lsra_checker (.*);

[test/linear_scan_register_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_tb
// Streams live intervals into the allocator and checks every assignment,
// spill and victim replacement against a cycle-free model of linear scan
// kept inside the bench, with random idling on both sides.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_tb;

  localparam int NINT   = lsra_pkg::INT_REGS_DEF;
  localparam int NFLT   = lsra_pkg::FP_REGS_DEF;
  localparam int RW     = lsra_pkg::REG_W;
  localparam int I_BASE = lsra_pkg::INT_BASE;
  localparam int F_BASE = lsra_pkg::FLOAT_BASE;
  localparam int DEPTH  = NINT + NFLT;
  localparam int NUM_ITEMS = 1050;

  typedef struct packed {
    logic [11:0] id;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic        fp_class;
    logic        new_pass;
  } interval_t;

  typedef struct packed {
    logic [11:0]   id;
    logic [RW-1:0] preg;
    logic          spilled;
    logic          any_spill;
    logic          last;
  } alloc_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // interval_id, interval_start, interval_end
  logic [1:0]  s_tuser = '0;   // fp_class, first_of_pass
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // result_id, phys_reg
  logic [1:0]  m_tuser;        // spilled, any_spill
  logic        m_tlast;

  linear_scan_register_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  interval_t pending_intervals[$];
  alloc_t    expected_allocs[$];
  interval_t cur_interval;

  int n_sent     = 0;
  int n_results  = 0;
  int n_spills   = 0;
  int n_replaced = 0;
  int n_errors   = 0;
  int gap_left   = 0;
  int gap_pct    = 10;
  int stall_left = 0;
  int stall_pct  = 10;
  logic tail_phase = 1'b0;

  // allocator state as the bench sees it
  logic [11:0]     act_id  [DEPTH];
  logic [15:0]     act_end [DEPTH];
  logic [RW-1:0]   act_reg [DEPTH];
  logic            act_flt [DEPTH];
  int              act_cnt = 0;
  logic [NINT-1:0] int_free = '1;
  logic [NFLT-1:0] flt_free = '1;
  logic            spill_seen = 1'b0;

  function automatic void drop_active(input int pos);
    for (int i = pos; i + 1 < act_cnt; i++) begin
      act_id[i]  = act_id[i+1];
      act_end[i] = act_end[i+1];
      act_reg[i] = act_reg[i+1];
      act_flt[i] = act_flt[i+1];
    end
    act_cnt--;
  endfunction

  // equal ends keep arrival order: new entry lands after them
  function automatic void push_active(input logic [11:0] id, input logic [15:0] e,
                                      input logic [RW-1:0] r, input logic f);
    int pos;
    pos = 0;
    if (act_cnt >= DEPTH) return;
    while (pos < act_cnt && act_end[pos] <= e) pos++;
    for (int i = act_cnt; i > pos; i--) begin
      act_id[i]  = act_id[i-1];
      act_end[i] = act_end[i-1];
      act_reg[i] = act_reg[i-1];
      act_flt[i] = act_flt[i-1];
    end
    act_id[pos]  = id;
    act_end[pos] = e;
    act_reg[pos] = r;
    act_flt[pos] = f;
    act_cnt++;
  endfunction

  function automatic void expect_alloc(input logic [11:0] id, input logic [RW-1:0] r,
                                       input logic sp, input logic lst);
    alloc_t a;
    a.id        = id;
    a.preg      = r;
    a.spilled   = sp;
    a.any_spill = spill_seen;
    a.last      = lst;
    expected_allocs.insert(expected_allocs.size(), a);
  endfunction

  function automatic void allocate(input interval_t it);
    int vic;
    int k;
    logic found;
    logic [RW-1:0] r;
    vic = 0;
    found = 1'b0;
    r = '0;
    if (it.new_pass) begin
      act_cnt = 0;
      int_free = '1;
      flt_free = '1;
      spill_seen = 1'b0;
    end
    // expire everything that ended before this start
    while (act_cnt > 0 && act_end[0] < it.start_pos) begin
      if (act_flt[0]) begin
        if (act_reg[0] >= F_BASE && act_reg[0] < F_BASE + NFLT)
          flt_free[act_reg[0] - F_BASE] = 1'b1;
      end else if (act_reg[0] >= I_BASE && act_reg[0] < I_BASE + NINT) begin
        int_free[act_reg[0] - I_BASE] = 1'b1;
      end
      drop_active(0);
    end
    if (it.fp_class && flt_free != '0) begin
      for (k = NFLT - 1; k >= 0; k--) if (flt_free[k]) r = RW'(F_BASE + k);
      flt_free[r - F_BASE] = 1'b0;
      push_active(it.id, it.end_pos, r, 1'b1);
      expect_alloc(it.id, r, 1'b0, 1'b1);
      return;
    end
    if (!it.fp_class && int_free != '0) begin
      for (k = NINT - 1; k >= 0; k--) if (int_free[k]) r = RW'(I_BASE + k);
      int_free[r - I_BASE] = 1'b0;
      push_active(it.id, it.end_pos, r, 1'b0);
      expect_alloc(it.id, r, 1'b0, 1'b1);
      return;
    end
    // class full: victim is the last entry of this class in end order
    spill_seen = 1'b1;
    n_spills++;
    for (k = 0; k < act_cnt; k++) begin
      if (act_flt[k] == it.fp_class) begin
        vic = k;
        found = 1'b1;
      end
    end
    if (found && act_end[vic] > it.end_pos) begin
      r = act_reg[vic];
      expect_alloc(act_id[vic], '0, 1'b1, 1'b0);
      drop_active(vic);
      push_active(it.id, it.end_pos, r, it.fp_class);
      expect_alloc(it.id, r, 1'b0, 1'b1);
      n_replaced++;
    end else begin
      expect_alloc(it.id, '0, 1'b1, 1'b1);
    end
  endfunction

  task automatic add_interval(input int id, input int s, input int e,
                              input bit f, input bit p);
    interval_t it;
    it.id        = 12'(id);
    it.start_pos = 16'(s);
    it.end_pos   = 16'(e);
    it.fp_class  = f;
    it.new_pass  = p;
    pending_intervals.insert(pending_intervals.size(), it);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        allocate(cur_interval);
        n_sent++;
      end
      tail_phase <= (pending_intervals.size() < 60);
      if ($urandom_range(0, 39) == 0) gap_pct <= $urandom_range(0, 2) * 15;
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_intervals.size() > 0) begin
        cur_interval = pending_intervals.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, cur_interval.end_pos, cur_interval.start_pos, cur_interval.id};
        s_tuser  <= {cur_interval.new_pass, cur_interval.fp_class};
        if (!tail_phase && $urandom_range(0, 99) < gap_pct)
          gap_left <= $urandom_range(1, 14);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    alloc_t got;
    alloc_t want;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.id        = m_tdata[11:0];
        got.preg      = m_tdata[17:12];
        got.spilled   = m_tuser[0];
        got.any_spill = m_tuser[1];
        got.last      = m_tlast;
        n_results++;
        if (expected_allocs.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result id=%0d reg=%0d spilled=%0b any=%0b last=%0b",
                     got.id, got.preg, got.spilled, got.any_spill, got.last);
        end else begin
          want = expected_allocs.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch at %0t: exp id=%0d reg=%0d sp=%0b any=%0b last=%0b",
                       $realtime, want.id, want.preg, want.spilled, want.any_spill,
                       want.last);
              $display("  got id=%0d reg=%0d sp=%0b any=%0b last=%0b",
                       got.id, got.preg, got.spilled, got.any_spill, got.last);
            end
          end
        end
        if ($urandom_range(0, 63) == 0) stall_pct <= $urandom_range(0, 2) * 12;
      end
      if (stall_left > 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 13);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int s;
    int e;
    int plen;
    int step_max;
    int span_max;
    int flt_pct;
    int total;

    // integer class: fill, then victim replacement and self spill
    add_interval(0, 0, 65535, 0, 1);
    add_interval(1, 1, 100, 0, 0);
    add_interval(2, 2, 100, 0, 0);
    add_interval(3, 3, 200, 0, 0);
    add_interval(4, 4, 300, 0, 0);
    add_interval(5, 5, 400, 0, 0);
    add_interval(6, 6, 500, 0, 0);
    add_interval(7, 7, 50, 0, 0);
    add_interval(8, 8, 65535, 0, 0);
    add_interval(9, 9, 400, 0, 0);
    add_interval(10, 9, 100, 0, 0);
    // float side, end below start, out of order start
    add_interval(11, 10, 10, 1, 0);
    add_interval(12, 11, 5, 1, 0);
    add_interval(13, 12, 20, 1, 0);
    add_interval(14, 3, 60, 0, 0);
    add_interval(15, 150, 150, 0, 0);
    // field extremes in a fresh pass
    add_interval(4095, 65535, 65535, 1, 1);
    add_interval(2730, 0, 0, 0, 0);
    add_interval(1365, 65535, 0, 1, 0);
    add_interval(4095, 32768, 65535, 0, 1);
    total = 20;

    // mostly well-formed passes with rising starts, some noise
    while (total < NUM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        plen     = $urandom_range(8, 90);
        s        = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 2000);
        step_max = $urandom_range(0, 12);
        case ($urandom_range(0, 2))
          0: span_max = 8;
          1: span_max = 200;
          default: span_max = 3000;
        endcase
        flt_pct = $urandom_range(0, 100);
        for (int i = 0; i < plen; i++) begin
          s = s + $urandom_range(0, step_max);
          if (s > 65535) s = 65535;
          e = s + $urandom_range(0, span_max);
          if (e > 65535) e = 65535;
          if ($urandom_range(0, 19) == 0) e = $urandom_range(0, s);
          add_interval($urandom_range(0, 4095), s, e,
                       $urandom_range(0, 99) < flt_pct, i == 0);
        end
        total += plen;
      end else begin
        plen = $urandom_range(5, 20);
        for (int i = 0; i < plen; i++)
          add_interval($urandom_range(0, 4095), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 1) != 0,
                       $urandom_range(0, 7) == 0);
        total += plen;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_intervals.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_allocs.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("%0d intervals allocated, %0d results checked", n_sent, n_results);
    $display("%0d full-class spills, %0d victim replacements, %0d errors",
             n_spills, n_replaced, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d results still outstanding", expected_allocs.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
